// File: rtl/chtl_pkg.sv
// Shared types and constants of the chained hash table lookup unit.
// Used by every module in this folder; depends on nothing.
package chtl_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned QueueDepth    = 2;

  localparam int unsigned SlotW   = 10;
  localparam int unsigned WordW   = 32;
  localparam int unsigned RsizeW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned InDataW = 152;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] HashSeed = 32'hffcc_ff44;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [StatusW-1:0] ST_FOUND  = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY  = 3'd1;
  localparam logic [StatusW-1:0] ST_ABSENT = 3'd2;
  localparam logic [StatusW-1:0] ST_BOUNDS = 3'd3;
  localparam logic [StatusW-1:0] ST_LONG   = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_CAPACITY_MASK = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEMORY_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RECORD_SIZE   = 2'd2;

  localparam logic [SlotW-1:0]  CapMaskRst = 10'd1023;
  localparam logic [WordW-1:0]  MemLenRst  = 32'd0;
  localparam logic [RsizeW-1:0] RsizeRst   = 16'd256;

  typedef struct packed {
    logic [SlotW-1:0]  capacity_mask;
    logic [WordW-1:0]  memory_length;
    logic [RsizeW-1:0] record_size;
  } cfg_t;

  // key carries item_id and hash carries the mixed id for a lookup
  typedef struct packed {
    logic             cmd;
    logic [SlotW-1:0] index;
    logic [WordW-1:0] key;
    logic [WordW-1:0] hash;
    logic [WordW-1:0] offset;
    logic             has_next;
    logic [SlotW-1:0] next;
  } entry_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

  function automatic logic [WordW-1:0] mix_id(input logic [WordW-1:0] id);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = HashSeed ^ id;
    b = rotl(id, 14);
    a = a - b;
    b = rotl(b, 5) ^ a;
    mix_id = b - rotl(a, 13);
  endfunction

endpackage

// File: rtl/chtl_fifo.sv
// Short request queue between the front and the back of the lookup unit.
// Depends on chtl_pkg for the entry type.
module chtl_fifo #(
  parameter int unsigned DEPTH = chtl_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  chtl_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output chtl_pkg::entry_t rdata_o
);
  import chtl_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/chtl_front.sv
// Front end: accepts stream requests, hashes lookup ids and queues them.
// Depends on chtl_pkg and chtl_fifo.
module chtl_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          enable_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [chtl_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          pop_i,
  output logic                          valid_o,
  output chtl_pkg::entry_t              entry_o
);
  import chtl_pkg::*;

  entry_t entry;
  logic   full;
  logic   push;

  always_comb begin
    entry.cmd      = s_axis_tuser;
    entry.index    = s_axis_tdata[9:0];
    entry.offset   = s_axis_tdata[105:74];
    entry.has_next = s_axis_tdata[106];
    entry.next     = s_axis_tdata[116:107];
    if (s_axis_tuser == CMD_LOOKUP) begin
      entry.key  = s_axis_tdata[148:117];
      entry.hash = mix_id(s_axis_tdata[148:117]);
    end else begin
      entry.key  = s_axis_tdata[41:10];
      entry.hash = s_axis_tdata[73:42];
    end
  end

  assign s_axis_tready = enable_i && !full;
  assign push          = s_axis_tvalid && s_axis_tready;

  chtl_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(entry),
    .full_o (full),
    .pop_i  (pop_i),
    .valid_o(valid_o),
    .rdata_o(entry_o)
  );

endmodule

// File: rtl/chtl_back.sv
// Back end: table memories, clearing pass, chain walk and result register.
// Depends on chtl_pkg.
module chtl_back #(
  parameter int unsigned TABLE_DEPTH = chtl_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chtl_pkg::cfg_t                cfg_i,
  output logic                          ready_o,
  input  logic                          valid_i,
  input  chtl_pkg::entry_t              entry_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [chtl_pkg::WordW-1:0]    m_axis_tdata,
  output logic [chtl_pkg::StatusW-1:0]  m_axis_tuser
);
  import chtl_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned VisW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LinkW = SlotW + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_e;

  state_e            state_q;
  logic [AddrW-1:0]  clr_q;
  logic [VisW-1:0]   visited_q;
  logic [SlotW-1:0]  slot_q;
  logic              first_q;
  logic [WordW-1:0]  id_q;
  logic              out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [WordW-1:0]  out_offset_q;

  logic [WordW-1:0]  keys_mem    [TABLE_DEPTH];
  logic [WordW-1:0]  hashes_mem  [TABLE_DEPTH];
  logic [WordW-1:0]  offsets_mem [TABLE_DEPTH];
  logic [LinkW-1:0]  links_mem   [TABLE_DEPTH];
  logic [WordW-1:0]  key_rd_q;
  logic [WordW-1:0]  hash_rd_q;
  logic [WordW-1:0]  off_rd_q;
  logic [LinkW-1:0]  link_rd_q;

  logic              out_free;
  logic              is_lookup;
  logic [SlotW-1:0]  slot;
  logic              slot_ok;
  logic              wr_ok;
  logic              tbl_we;
  logic              off_we;
  logic [AddrW-1:0]  off_wa;
  logic [WordW-1:0]  off_wd;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic              res_load;

  // evaluation of the entry just read
  logic              not_main;
  logic              key_hit;
  logic              over_bounds;
  logic              link_end;
  logic              too_long;
  logic              hop;
  logic [StatusW-1:0] eval_status;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_lookup = (entry_i.cmd == CMD_LOOKUP);
  assign slot      = entry_i.hash[SlotW-1:0] & cfg_i.capacity_mask;
  assign slot_ok   = (32'(slot) < 32'(TABLE_DEPTH));
  assign wr_ok     = (32'(entry_i.index) < 32'(TABLE_DEPTH));
  assign ready_o   = (state_q != S_CLEAR);

  // a lookup waits until the result register can take its answer
  assign pop_o = (state_q == S_IDLE) && valid_i && (!is_lookup || !out_valid_q);

  assign not_main = first_q &&
                    ((off_rd_q == '0) ||
                     ((hash_rd_q[SlotW-1:0] & cfg_i.capacity_mask) != slot_q));
  assign key_hit     = (key_rd_q == id_q);
  assign over_bounds = ({1'b0, off_rd_q} + 33'(cfg_i.record_size)) >
                       {1'b0, cfg_i.memory_length};
  assign link_end    = !link_rd_q[SlotW] ||
                       (32'(link_rd_q[SlotW-1:0]) >= 32'(TABLE_DEPTH));
  assign too_long    = (visited_q >= VisW'(TABLE_DEPTH));
  assign hop         = (state_q == S_EVAL) && !not_main && !key_hit && !link_end &&
                       !too_long;

  // answer loaded into the result register this cycle
  assign res_load = (pop_o && is_lookup && !slot_ok) ||
                    ((state_q == S_EVAL) && !hop && out_free);

  always_comb begin
    if (not_main) begin
      eval_status = ST_EMPTY;
    end else if (key_hit) begin
      if (off_rd_q == '0) begin
        eval_status = ST_ABSENT;
      end else if (over_bounds) begin
        eval_status = ST_BOUNDS;
      end else begin
        eval_status = ST_FOUND;
      end
    end else if (link_end) begin
      eval_status = ST_ABSENT;
    end else begin
      eval_status = ST_LONG;
    end
  end

  assign tbl_we = pop_o && !is_lookup && wr_ok;
  assign off_we = (state_q == S_CLEAR) || tbl_we;
  assign off_wa = (state_q == S_CLEAR) ? clr_q : AddrW'(entry_i.index);
  assign off_wd = (state_q == S_CLEAR) ? '0 : entry_i.offset;
  assign rd_en  = (pop_o && is_lookup && slot_ok) || hop;
  assign rd_addr = (state_q == S_EVAL) ? AddrW'(link_rd_q[SlotW-1:0]) : AddrW'(slot);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      keys_mem[AddrW'(entry_i.index)]   <= entry_i.key;
      hashes_mem[AddrW'(entry_i.index)] <= entry_i.hash;
      links_mem[AddrW'(entry_i.index)]  <= entry_i.has_next ? {1'b1, entry_i.next} : '0;
    end
    if (off_we) begin
      offsets_mem[off_wa] <= off_wd;
    end
    if (rd_en) begin
      key_rd_q  <= keys_mem[rd_addr];
      hash_rd_q <= hashes_mem[rd_addr];
      off_rd_q  <= offsets_mem[rd_addr];
      link_rd_q <= links_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      visited_q    <= '0;
      slot_q       <= '0;
      first_q      <= 1'b0;
      id_q         <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_FOUND;
      out_offset_q <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(TABLE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o && is_lookup) begin
            if (slot_ok) begin
              state_q   <= S_EVAL;
              slot_q    <= slot;
              id_q      <= entry_i.key;
              first_q   <= 1'b1;
              visited_q <= VisW'(1);
            end else begin
              out_status_q <= ST_EMPTY;
              out_offset_q <= '0;
            end
          end
        end
        S_EVAL: begin
          first_q <= 1'b0;
          if (hop) begin
            visited_q <= visited_q + 1'b1;
          end else if (out_free) begin
            state_q      <= S_IDLE;
            out_status_q <= eval_status;
            out_offset_q <= (eval_status == ST_FOUND) ? off_rd_q : '0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_offset_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/chained_hash_table_lookup_unit.sv
// Chained hash table lookup unit: configuration registers, front end and back end.
// A lookup makes one table read per chain entry compared, then loads its answer into the
// result register, which must drain before the next lookup leaves the queue; no request
// leaves the queue while a lookup walks its chain.
// Reset: asynchronous, active low; a clearing pass then empties the offset memory, and no
// request is accepted until it ends.
module chained_hash_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH = chtl_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [chtl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [chtl_pkg::WordW-1:0]    cfg_data_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index, entry_key, entry_hash, entry_offset, entry_has_next, entry_next,
  // item_id, zero fill
  input  logic [chtl_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // record_offset
  output logic [chtl_pkg::WordW-1:0]    m_axis_tdata,
  // status
  output logic [chtl_pkg::StatusW-1:0]  m_axis_tuser
);
  import chtl_pkg::*;

  cfg_t   cfg_q;
  logic   back_ready;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity_mask <= CapMaskRst;
      cfg_q.memory_length <= MemLenRst;
      cfg_q.record_size   <= RsizeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CAPACITY_MASK: cfg_q.capacity_mask <= cfg_data_i[SlotW-1:0];
        REG_MEMORY_LENGTH: cfg_q.memory_length <= cfg_data_i;
        REG_RECORD_SIZE:   cfg_q.record_size   <= cfg_data_i[RsizeW-1:0];
        default: begin
        end
      endcase
    end
  end

  chtl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (back_ready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .entry_o      (q_entry)
  );

  chtl_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ready_o      (back_ready),
    .valid_i      (q_valid),
    .entry_i      (q_entry),
    .pop_o        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// File: verif/chained_hash_table_lookup_unit_tb.sv
// Self-checking testbench of chained_hash_table_lookup_unit: loads table entries, builds
// collision chains, runs lookups under several register settings and checks every answer.
// Depends on rtl/chtl_pkg.sv and rtl/chained_hash_table_lookup_unit.sv.
`timescale 1ns / 1ps

module chained_hash_table_lookup_unit_tb;
  import chtl_pkg::*;

  localparam int unsigned Depth   = TableDepthDef;
  localparam int unsigned NumSets = 5;
  localparam int unsigned SetReqs = 180;

  typedef struct {
    logic             cmd;
    logic [SlotW-1:0] index;
    logic [WordW-1:0] key;
    logic [WordW-1:0] hash;
    logic [WordW-1:0] offset;
    logic             has_next;
    logic [SlotW-1:0] next;
    logic [WordW-1:0] item_id;
  } req_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   offset;
  } answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [WordW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [WordW-1:0]    m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  chained_hash_table_lookup_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // register settings, one per phase
  logic [SlotW-1:0]  set_mask   [NumSets] = '{10'd1023, 10'd0, 10'd63, 10'd15, 10'd511};
  logic [WordW-1:0]  set_memlen [NumSets] = '{32'h0001_0000, 32'h4000_0000, 32'hffff_ffff,
                                              32'h0, 32'h8000_0000};
  logic [RsizeW-1:0] set_rsize  [NumSets] = '{16'd256, 16'd65535, 16'd1, 16'd256, 16'd4096};

  // shadow of the table and registers, updated as requests are accepted
  logic [SlotW-1:0]  cfg_mask   = CapMaskRst;
  logic [WordW-1:0]  cfg_memlen = MemLenRst;
  logic [RsizeW-1:0] cfg_rsize  = RsizeRst;
  logic [WordW-1:0]  tbl_key  [Depth];
  logic [WordW-1:0]  tbl_hash [Depth];
  logic [WordW-1:0]  tbl_off  [Depth] = '{default: '0};
  logic [SlotW:0]    tbl_link [Depth] = '{default: '0};

  req_t             pending_reqs[$];
  answer_t          answers_due[$];
  logic [WordW-1:0] planted_ids[$];
  logic [SlotW-1:0] written_slots[$];
  logic [Depth-1:0] slot_written = '0;

  req_t cur_req;
  int   cyc = 0;
  int   pushed_cnt = 0;
  int   taken_cnt = 0;
  int   lookups_taken = 0;
  int   err_cnt = 0;
  int   status_seen [8] = '{default: 0};
  int   hold_cnt = 0;
  logic hold_used = 1'b0;
  wire  calm = (cyc % 5000) < 1200;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic logic [WordW-1:0] scramble_id(input logic [WordW-1:0] id);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = HashSeed ^ id;
    b = {id[17:0], id[31:18]};
    a = a - b;
    b = {b[26:0], b[31:27]} ^ a;
    return b - {a[18:0], a[31:19]};
  endfunction

  function automatic logic [StatusW-1:0] probe_table(input logic [WordW-1:0] id,
                                                     output logic [WordW-1:0] found_off);
    logic [WordW-1:0] slot;
    logic [SlotW-1:0] cur;
    logic [SlotW:0]   link;
    found_off = '0;
    slot = scramble_id(id) & {22'b0, cfg_mask};
    if (slot >= Depth) return ST_EMPTY;
    cur = slot[SlotW-1:0];
    if (tbl_off[cur] == '0) return ST_EMPTY;
    if ((tbl_hash[cur] & {22'b0, cfg_mask}) != slot) return ST_EMPTY;
    for (int hops = 1; hops <= Depth; hops++) begin
      if (tbl_key[cur] == id) begin
        if (tbl_off[cur] == '0) return ST_ABSENT;
        if (64'(tbl_off[cur]) + 64'(cfg_rsize) > 64'(cfg_memlen)) return ST_BOUNDS;
        found_off = tbl_off[cur];
        return ST_FOUND;
      end
      link = tbl_link[cur];
      if (!link[SlotW] || link[SlotW-1:0] >= Depth) return ST_ABSENT;
      // walked a full table without a match and still linking onward
      if (hops >= Depth) return ST_LONG;
      cur = link[SlotW-1:0];
    end
    return ST_LONG;
  endfunction

  function automatic void apply_request(input req_t r);
    answer_t ans;
    if (r.cmd == CMD_WRITE) begin
      tbl_key[r.index]  = r.key;
      tbl_hash[r.index] = r.hash;
      tbl_off[r.index]  = r.offset;
      tbl_link[r.index] = r.has_next ? {1'b1, r.next} : '0;
    end else begin
      ans.status = probe_table(r.item_id, ans.offset);
      answers_due.push_back(ans);
      lookups_taken++;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(cur_req);
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tdata  <= {3'b0, cur_req.item_id, cur_req.next, cur_req.has_next,
                            cur_req.offset, cur_req.hash, cur_req.key, cur_req.index};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // answer monitor
  always @(posedge clk_i or negedge rst_ni) begin : answer_mon
    answer_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          err_cnt++;
          $display("%0t: answer with none expected: status %0d offset %h", $time,
                   m_axis_tuser, m_axis_tdata);
        end else begin
          want = answers_due.pop_front();
          status_seen[want.status]++;
          if (m_axis_tuser !== want.status || m_axis_tdata !== want.offset) begin
            err_cnt++;
            $display("%0t: expected status %0d offset %h, actual status %0d offset %h",
                     $time, want.status, want.offset, m_axis_tuser, m_axis_tdata);
          end
        end
      end
      // one long hold-off so the block backs up into the request side
      if (!hold_used && lookups_taken >= 300) begin
        hold_used = 1'b1;
        hold_cnt  = 600;
      end else if (hold_cnt != 0) begin
        hold_cnt--;
      end
      m_axis_tready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 9);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CAPACITY_MASK: cfg_mask   = val[SlotW-1:0];
      REG_MEMORY_LENGTH: cfg_memlen = val;
      REG_RECORD_SIZE:   cfg_rsize  = val[RsizeW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_write(input logic [SlotW-1:0] idx, input logic [WordW-1:0] key,
                            input logic [WordW-1:0] hash, input logic [WordW-1:0] off,
                            input logic has_next, input logic [SlotW-1:0] next);
    req_t r;
    r = '{CMD_WRITE, idx, key, hash, off, has_next, next, $urandom};
    if (!slot_written[idx]) begin
      slot_written[idx] = 1'b1;
      written_slots.push_back(idx);
    end
    pending_reqs.push_back(r);
    pushed_cnt++;
  endtask

  task automatic push_lookup(input logic [WordW-1:0] id);
    req_t r;
    r = '{CMD_LOOKUP, SlotW'($urandom), $urandom, $urandom, $urandom, 1'($urandom),
          SlotW'($urandom), id};
    pending_reqs.push_back(r);
    pushed_cnt++;
  endtask

  function automatic logic [SlotW-1:0] any_written();
    return written_slots[$urandom_range(written_slots.size() - 1)];
  endfunction

  function automatic logic [WordW-1:0] pick_offset();
    logic [WordW-1:0] v;
    if (cfg_memlen > cfg_rsize && $urandom_range(9) < 8)
      return $urandom_range(cfg_memlen - cfg_rsize, 1);
    v = $urandom;
    return (v == '0) ? 32'd1 : v;
  endfunction

  function automatic logic [SlotW-1:0] home_slot(input logic [WordW-1:0] id);
    logic [WordW-1:0] h;
    h = scramble_id(id) & {22'b0, cfg_mask};
    return h[SlotW-1:0];
  endfunction

  // chain written tail first so every link points at a slot that holds data;
  // the id sits at hit_pos, or nowhere when hit_pos >= len
  task automatic plant_chain(input logic [WordW-1:0] id, input int len, input int hit_pos,
                             input logic [WordW-1:0] hit_off);
    logic [SlotW-1:0] path [6];
    logic [WordW-1:0] key;
    logic [WordW-1:0] hash;
    logic [WordW-1:0] off;
    logic             has_next;
    logic [SlotW-1:0] next;
    path[0] = home_slot(id);
    for (int k = 1; k < len; k++) path[k] = SlotW'($urandom);
    for (int k = len - 1; k >= 0; k--) begin
      key  = (k == hit_pos) ? id : $urandom;
      off  = (k == hit_pos) ? hit_off : pick_offset();
      hash = (k == 0) ? (($urandom & ~{22'b0, cfg_mask}) | {22'b0, path[0]}) : $urandom;
      if (k == len - 1) begin
        has_next = written_slots.size() != 0 && $urandom_range(99) < 15;
        next     = has_next ? any_written() : SlotW'($urandom);
      end else begin
        has_next = 1'b1;
        next     = path[k + 1];
      end
      push_write(path[k], key, hash, off, has_next, next);
    end
    planted_ids.push_back(id);
    push_lookup(id);
  endtask

  task automatic drain();
    while (taken_cnt != pushed_cnt || answers_due.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  initial begin
    int               sel;
    int               len;
    int               target;
    logic [WordW-1:0] id;
    logic [WordW-1:0] off;
    logic [SlotW-1:0] h;
    logic [SlotW-1:0] idx;
    logic             link;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumSets; p++) begin
      write_reg(REG_CAPACITY_MASK, {22'b0, set_mask[p]});
      write_reg(REG_MEMORY_LENGTH, set_memlen[p]);
      write_reg(REG_RECORD_SIZE, {16'b0, set_rsize[p]});

      if (p == 0) begin
        // empty table, then the edges of the bounds check
        push_lookup(32'h0);
        push_lookup(32'hffff_ffff);
        plant_chain(32'hffff_ffff, 1, 0, cfg_memlen - cfg_rsize);
        plant_chain(32'h0, 1, 0, cfg_memlen - cfg_rsize + 1);
        // key matches an entry whose offset was cleared
        plant_chain(32'h1234_5678, 2, 1, 32'h0);
        // key not in the chain
        plant_chain(32'h9abc_def0, 3, 3, pick_offset());
        push_write(10'd1023, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 10'd1023);
        push_write(10'd0, 32'h0, 32'h0, 32'h0, 1'b1, 10'd1023);
        // occupant does not sit in its main position
        id = 32'h0bad_f00d;
        h  = home_slot(id);
        push_write(h, id, {22'($urandom_range(32'h3f_ffff)), h ^ 10'd1}, pick_offset(), 1'b0,
                   '0);
        push_lookup(id);
        // chain that loops back on itself
        id = 32'h5eed_cafe;
        h  = home_slot(id);
        push_write(h, ~id, scramble_id(id), pick_offset(), 1'b1, h);
        push_lookup(id);
      end else if (p == 2) begin
        plant_chain(32'h7777_0001, 1, 0, 32'hffff_fffe);
        plant_chain(32'h7777_0002, 1, 0, 32'hffff_ffff);
      end

      target = pushed_cnt + SetReqs;
      while (pushed_cnt < target) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          len = $urandom_range(5, 1);
          case ($urandom_range(9))
            0:       off = '0;
            1:       off = $urandom;
            default: off = pick_offset();
          endcase
          plant_chain($urandom, len, $urandom_range(5), off);
        end else if (sel < 70 && planted_ids.size() != 0) begin
          push_lookup(planted_ids[$urandom_range(planted_ids.size() - 1)]);
        end else if (sel < 82) begin
          idx  = SlotW'($urandom);
          link = 1'($urandom_range(1));
          if (link && written_slots.size() == 0) link = 1'b0;
          off  = ($urandom_range(4) == 0) ? '0 : $urandom;
          push_write(idx, $urandom, $urandom, off, link,
                     !link ? SlotW'($urandom) :
                     ($urandom_range(3) == 0 ? idx : any_written()));
        end else if (sel < 92) begin
          push_lookup($urandom);
        end else if (sel < 98) begin
          id = $urandom;
          h  = home_slot(id);
          push_write(h, id, {22'($urandom_range(32'h3f_ffff)), h ^ 10'd1}, pick_offset(),
                     1'b0, SlotW'($urandom));
          push_lookup(id);
        end else begin
          id = $urandom;
          h  = home_slot(id);
          push_write(h, ~id, scramble_id(id), pick_offset(), 1'b1, h);
          push_lookup(id);
        end
      end
      drain();
    end

    $display("ran %0d requests (%0d lookups) under %0d register settings", taken_cnt,
             lookups_taken, NumSets);
    $display("answers: found %0d, empty or off home %0d, absent %0d, out of bounds %0d, loop %0d",
             status_seen[ST_FOUND], status_seen[ST_EMPTY], status_seen[ST_ABSENT],
             status_seen[ST_BOUNDS], status_seen[ST_LONG]);
    if (err_cnt == 0) begin
      $display("chained_hash_table_lookup_unit: match");
    end else begin
      $display("chained_hash_table_lookup_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("timeout: %0d requests pending, %0d answers due", pushed_cnt - taken_cnt,
             answers_due.size());
    $display("chained_hash_table_lookup_unit: mismatch");
    $finish;
  end

endmodule
